// File: rtl/plsdr_pkg.sv
// Shared constants for the path-length sign-demodulation regulator.
package plsdr_pkg;

	localparam int INT_SHIFT  = 6;
	localparam int RATE_SHIFT = 18;

	localparam int DATA_W  = 16;
	localparam int INT_W   = DATA_W + INT_SHIFT + 1;
	localparam int SUM_W   = 32;
	localparam int RATE_W  = SUM_W - RATE_SHIFT;
	localparam int RUN_W   = 8;
	localparam int ADDR_W  = 5;
	localparam int PDATA_W = 32;

	localparam logic signed [INT_W:0] INT_LIM = (INT_W + 1)'(32767) <<< INT_SHIFT;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic [2:0] REG_DELAY_REF   = 3'd0;
	localparam logic [2:0] REG_MAX_DELAY   = 3'd1;
	localparam logic [2:0] REG_GAIN        = 3'd2;
	localparam logic [2:0] REG_LOOP_CLOSED = 3'd3;
	localparam logic [2:0] REG_START_VALUE = 3'd4;

	localparam logic [RUN_W-1:0] MAX_DELAY_RST = 8'd100;

	localparam logic signed [1:0] SIGN_POS = 2'sb01;
	localparam logic signed [1:0] SIGN_NEG = 2'sb11;

endpackage

// File: rtl/path_length_sign_demod_regulator.sv
// Path-length regulator: square-wave delay, sign demodulation, integrator, rate dump.
//
//  channel | direction | signals                                   | accepted when
//  in      | to block  | phase_error, modulator_sample, dump_now   | in_valid & in_ready
//  out     | from blk  | drive_value, rate_output, phase_sign      | out_valid & out_ready
//  cfg     | to block  | psel penable pwrite paddr pwdata prdata   | psel & penable & pwrite
//
//  One item per cycle while in_ready is high: all state updates and the result happen in the accept cycle,
//  and the result appears in the output register in the following cycle.
//  The integrator add-and-saturate feeds back through integ_q.
//  in_ready drops only while a result waits in the output register and out_ready is low.
//  Reset clears the run counters, rate sum and hold; held drive, integrator and start_value clear to zero.
module path_length_sign_demod_regulator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [plsdr_pkg::DATA_W-1:0]     phase_error,
	input  logic signed [plsdr_pkg::DATA_W-1:0]     modulator_sample,
	input  logic                                    dump_now,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [plsdr_pkg::DATA_W-1:0]     drive_value,
	output logic signed [plsdr_pkg::RATE_W-1:0]     rate_output,
	output logic signed [1:0]                       phase_sign,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [plsdr_pkg::ADDR_W-1:0]            paddr,
	input  logic [plsdr_pkg::PDATA_W-1:0]           pwdata,
	output logic [plsdr_pkg::PDATA_W-1:0]           prdata,
	output logic                                    pready
);
	import plsdr_pkg::*;

	logic [RUN_W-1:0]               delay_ref_q, max_delay_q;
	logic signed [DATA_W-1:0]       gain_q, start_value_q;
	logic                           loop_closed_q;

	logic [RUN_W-1:0]               high_run_q, low_run_q;
	logic                           delayed_wave_q;
	logic signed [INT_W-1:0]        integ_q;
	logic signed [DATA_W-1:0]       held_drive_q;
	logic [SUM_W-1:0]               rate_sum_q;
	logic signed [RATE_W-1:0]       rate_hold_q;

	logic                           out_valid_q;
	logic signed [DATA_W-1:0]       drive_q;
	logic signed [RATE_W-1:0]       rate_q;
	logic signed [1:0]              sign_q;

	logic                           in_accept, cfg_wr;
	logic [2:0]                     cfg_idx;
	logic [RUN_W-1:0]               dly;
	logic                           wave, dwave_nxt, dwave_used, sign_pos;
	logic [RUN_W-1:0]               high_nxt, low_nxt;
	logic signed [DATA_W:0]         pe_ext, demod;
	logic signed [INT_W:0]          step, integ_sum;
	logic signed [INT_W-1:0]        integ_sat, integ_nxt, held_shl;
	logic signed [DATA_W-1:0]       held_nxt;
	logic [SUM_W-1:0]               sum_nxt;
	logic signed [RATE_W-1:0]       rate_hold_nxt;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign cfg_wr    = psel && penable && pwrite;
	assign cfg_idx   = paddr[4:2];
	assign pready    = 1'b1;

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign rate_output = rate_q;
	assign phase_sign  = sign_q;

	always_comb begin
		unique case (cfg_idx)
			REG_DELAY_REF:   prdata = PDATA_W'(delay_ref_q);
			REG_MAX_DELAY:   prdata = PDATA_W'(max_delay_q);
			REG_GAIN:        prdata = PDATA_W'($unsigned(gain_q));
			REG_LOOP_CLOSED: prdata = PDATA_W'(loop_closed_q);
			REG_START_VALUE: prdata = PDATA_W'($unsigned(start_value_q));
			default:         prdata = '0;
		endcase
	end

	// Square-wave delay by run counting
	always_comb begin
		dly  = (delay_ref_q < max_delay_q) ? delay_ref_q : max_delay_q;
		wave = !(modulator_sample > 0);
		high_nxt  = high_run_q;
		low_nxt   = low_run_q;
		dwave_nxt = delayed_wave_q;
		if (dly != '0) begin
			if (wave) begin
				low_nxt  = '0;
				high_nxt = (high_run_q == RUN_MAX) ? high_run_q : high_run_q + 1'b1;
			end else begin
				high_nxt = '0;
				low_nxt  = (low_run_q == RUN_MAX) ? low_run_q : low_run_q + 1'b1;
			end
			if (high_nxt == dly) begin
				dwave_nxt = 1'b1;
			end
			if (low_nxt == dly) begin
				dwave_nxt = 1'b0;
			end
		end
		dwave_used = (dly == '0) ? wave : dwave_nxt;
	end

	// Demodulation, integrator and rate sum
	always_comb begin
		sign_pos = (phase_error > 0) ^ dwave_used;
		pe_ext   = (DATA_W + 1)'(phase_error);
		demod    = dwave_used ? -pe_ext : pe_ext;

		step      = (INT_W + 1)'($signed({gain_q, 1'b0}));
		integ_sum = (INT_W + 1)'(integ_q) + (sign_pos ? step : -step);
		if (integ_sum > INT_LIM) begin
			integ_sat = INT_W'(INT_LIM);
		end else if (integ_sum < -INT_LIM) begin
			integ_sat = INT_W'(-INT_LIM);
		end else begin
			integ_sat = INT_W'(integ_sum);
		end

		held_shl = INT_W'(held_drive_q) <<< INT_SHIFT;
		if (loop_closed_q) begin
			held_nxt  = DATA_W'(integ_sat >>> INT_SHIFT);
			integ_nxt = integ_sat;
		end else begin
			held_nxt  = held_drive_q;
			integ_nxt = held_shl;
		end

		if (dump_now) begin
			rate_hold_nxt = $signed(rate_sum_q[SUM_W-1:RATE_SHIFT]);
			sum_nxt       = '0;
		end else begin
			rate_hold_nxt = rate_hold_q;
			sum_nxt       = rate_sum_q + SUM_W'($unsigned(SUM_W'(demod)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ref_q    <= '0;
			max_delay_q    <= MAX_DELAY_RST;
			gain_q         <= '0;
			loop_closed_q  <= 1'b0;
			start_value_q  <= '0;
			high_run_q     <= '0;
			low_run_q      <= '0;
			delayed_wave_q <= 1'b0;
			integ_q        <= '0;
			held_drive_q   <= '0;
			rate_sum_q     <= '0;
			rate_hold_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_accept) begin
				high_run_q     <= high_nxt;
				low_run_q      <= low_nxt;
				delayed_wave_q <= dwave_nxt;
				rate_sum_q     <= sum_nxt;
				rate_hold_q    <= rate_hold_nxt;
			end
			// A start value write reloads drive and integrator
			if (cfg_wr && cfg_idx == REG_START_VALUE) begin
				held_drive_q <= $signed(pwdata[DATA_W-1:0]);
				integ_q      <= INT_W'($signed(pwdata[DATA_W-1:0])) <<< INT_SHIFT;
			end else if (in_accept) begin
				integ_q      <= integ_nxt;
				held_drive_q <= held_nxt;
			end
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_DELAY_REF:   delay_ref_q   <= pwdata[RUN_W-1:0];
					REG_MAX_DELAY:   max_delay_q   <= pwdata[RUN_W-1:0];
					REG_GAIN:        gain_q        <= $signed(pwdata[DATA_W-1:0]);
					REG_LOOP_CLOSED: loop_closed_q <= pwdata[0];
					REG_START_VALUE: start_value_q <= $signed(pwdata[DATA_W-1:0]);
					default: ;
				endcase
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register: load on accept, hold while stalled
	always_ff @(posedge clk) begin
		if (in_accept) begin
			drive_q <= held_nxt;
			rate_q  <= rate_hold_nxt;
			sign_q  <= sign_pos ? SIGN_POS : SIGN_NEG;
		end
	end

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("in_ready low with empty output register");

	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(high_run_q != '0 && low_run_q != '0))
		else $error("high and low run counters both nonzero");

	a_sign_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (sign_q == SIGN_POS || sign_q == SIGN_NEG))
		else $error("phase_sign not +1 or -1");

	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && dump_now) |=> (rate_sum_q == '0))
		else $error("rate sum not cleared after dump");

	a_closed_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && loop_closed_q) |=>
			(drive_q != $signed({1'b1, {(DATA_W-1){1'b0}}})))
		else $error("closed-loop drive value outside saturation limits");
`endif

endmodule

// File: sim/path_length_sign_demod_regulator_test.sv
// Testbench for the path-length sign-demodulation regulator: random and directed items, scoreboard.
module path_length_sign_demod_regulator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import plsdr_pkg::*;

	localparam int LONG_HOLD     = 60;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_LIMIT   = 100;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic signed [RATE_W-1:0] rate;
		logic signed [1:0]        sign;
	} regulator_out_t;

	class regulator_scoreboard;
		logic [RUN_W-1:0]         delay_ref;
		logic [RUN_W-1:0]         max_delay;
		logic signed [DATA_W-1:0] gain;
		logic signed [DATA_W-1:0] start_value;
		logic                     loop_closed;
		logic [RUN_W-1:0]         high_run;
		logic [RUN_W-1:0]         low_run;
		logic                     delayed_wave;
		longint                   integrator;
		logic signed [DATA_W-1:0] held_drive;
		logic [SUM_W-1:0]         rate_sum;
		logic signed [RATE_W-1:0] rate_hold;
		regulator_out_t           drive_rate_q[$];
		int                       inputs;
		int                       results;
		int                       dumps;
		int                       mismatches;

		function new();
			delay_ref    = '0;
			max_delay    = MAX_DELAY_RST;
			gain         = '0;
			start_value  = '0;
			loop_closed  = 1'b0;
			high_run     = '0;
			low_run      = '0;
			delayed_wave = 1'b0;
			rate_sum     = '0;
			rate_hold    = '0;
			inputs       = 0;
			results      = 0;
			dumps        = 0;
			mismatches   = 0;
			load_start();
		endfunction

		function void load_start();
			held_drive = start_value;
			integrator = longint'(start_value) <<< INT_SHIFT;
		endfunction

		function int pending();
			return drive_rate_q.size();
		endfunction

		function void write_register(logic [2:0] index, logic [PDATA_W-1:0] value);
			case (index)
				REG_DELAY_REF:   delay_ref = value[RUN_W-1:0];
				REG_MAX_DELAY:   max_delay = value[RUN_W-1:0];
				REG_GAIN:        gain = value[DATA_W-1:0];
				REG_LOOP_CLOSED: loop_closed = value[0];
				REG_START_VALUE: begin
					start_value = value[DATA_W-1:0];
					load_start();
				end
				default: ;
			endcase
		endfunction

		// Advance the regulator by one sample and queue the result it owes.
		function void note_input(logic signed [DATA_W-1:0] pe, logic signed [DATA_W-1:0] mods,
				logic dump);
			logic                     wave;
			logic                     dwave;
			logic [RUN_W-1:0]         dly;
			logic                     positive;
			int                       demod;
			longint                   lim;
			logic signed [SUM_W-1:0]  sum_signed;
			regulator_out_t           r;
			wave = (mods > 0) ? 1'b0 : 1'b1;
			dly  = (delay_ref < max_delay) ? delay_ref : max_delay;
			if (dly == 0) begin
				dwave = wave;
			end else begin
				if (wave) begin
					low_run = '0;
					if (high_run != RUN_MAX) high_run++;
				end else begin
					high_run = '0;
					if (low_run != RUN_MAX) low_run++;
				end
				if (high_run == dly) delayed_wave = 1'b1;
				if (low_run == dly) delayed_wave = 1'b0;
				dwave = delayed_wave;
			end
			// zero counts as negative
			positive = (pe > 0);
			demod = int'(pe);
			if (dwave) begin
				positive = !positive;
				demod = -demod;
			end
			lim = longint'(32767) <<< INT_SHIFT;
			integrator += positive ? longint'(gain) * 2 : -longint'(gain) * 2;
			if (integrator > lim) integrator = lim;
			if (integrator < -lim) integrator = -lim;
			if (loop_closed)
				held_drive = DATA_W'(integrator >>> INT_SHIFT);
			else
				integrator = longint'(held_drive) <<< INT_SHIFT;
			if (dump) begin
				sum_signed = rate_sum;
				rate_hold = RATE_W'(sum_signed >>> RATE_SHIFT);
				rate_sum = '0;
				dumps++;
			end else begin
				rate_sum = rate_sum + SUM_W'(demod);
			end
			r.drive = held_drive;
			r.rate  = rate_hold;
			r.sign  = positive ? SIGN_POS : SIGN_NEG;
			drive_rate_q.push_back(r);
			inputs++;
		endfunction

		task report(string msg);
			mismatches++;
			// keep the log short when everything breaks
			if (mismatches <= PRINT_LIMIT) $display("[%0t] ERROR: %s", $time, msg);
		endtask

		task check_result(logic signed [DATA_W-1:0] drive, logic signed [RATE_W-1:0] rate,
				logic signed [1:0] sgn);
			regulator_out_t want;
			if (drive_rate_q.size() == 0) begin
				report($sformatf("result with no item outstanding: drive %0d rate %0d sign %0d",
					drive, rate, sgn));
				return;
			end
			want = drive_rate_q.pop_front();
			results++;
			if (drive !== want.drive)
				report($sformatf("result %0d drive_value: expected %0d got %0d",
					results, want.drive, drive));
			if (rate !== want.rate)
				report($sformatf("result %0d rate_output: expected %0d got %0d",
					results, want.rate, rate));
			if (sgn !== want.sign)
				report($sformatf("result %0d phase_sign: expected %0d got %0d",
					results, want.sign, sgn));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] phase_error = '0;
	logic signed [DATA_W-1:0] modulator_sample = '0;
	logic                     dump_now = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] drive_value;
	logic signed [RATE_W-1:0] rate_output;
	logic signed [1:0]        phase_sign;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;

	regulator_scoreboard sb;
	bit          send_idle = 1'b0;
	bit          recv_idle = 1'b0;
	bit          hold_request = 1'b0;
	logic [7:0]  cfg_delay_ref = '0;
	logic [7:0]  cfg_max_delay = MAX_DELAY_RST;
	int          settings = 1;

	path_length_sign_demod_regulator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.phase_error(phase_error),
		.modulator_sample(modulator_sample),
		.dump_now(dump_now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_value(drive_value),
		.rate_output(rate_output),
		.phase_sign(phase_sign),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(phase_error, modulator_sample, dump_now);
		if (arst_n && out_valid && out_ready)
			sb.check_result(drive_value, rate_output, phase_sign);
	end

	// Result side: random stall bursts, plus one long hold on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		#1_000_000;
		$display("run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(input logic signed [DATA_W-1:0] pe,
			input logic signed [DATA_W-1:0] mods, input logic dump);
		@(negedge clk);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid         <= 1'b1;
		phase_error      <= pe;
		modulator_sample <= mods;
		dump_now         <= dump;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic drain();
		int guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() > 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] index, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({index, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_register(index, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] dref, input logic [7:0] mdly,
			input logic signed [15:0] gn, input logic closed, input logic signed [15:0] start);
		drain();
		cfg_delay_ref = dref;
		cfg_max_delay = mdly;
		apb_write(REG_DELAY_REF, PDATA_W'(dref));
		apb_write(REG_MAX_DELAY, PDATA_W'(mdly));
		apb_write(REG_GAIN, PDATA_W'(gn));
		apb_write(REG_LOOP_CLOSED, PDATA_W'(closed));
		apb_write(REG_START_VALUE, PDATA_W'(start));
		settings++;
	endtask

	// Mostly a square wave whose runs straddle the delay, with some random noise samples.
	task automatic modulated_run(input int count, input bit idle_on, input bit long_hold,
			input bit long_runs);
		int                       run_left = 0;
		bit                       mod_high;
		int                       span;
		int                       dly;
		logic signed [DATA_W-1:0] pe;
		logic signed [DATA_W-1:0] mods;
		logic                     dump;
		dly = int'((cfg_delay_ref < cfg_max_delay) ? cfg_delay_ref : cfg_max_delay);
		span = (dly == 0) ? 8 : 2 * dly + 2;
		send_idle = idle_on;
		recv_idle = idle_on;
		if (long_hold) hold_request = 1'b1;
		mod_high = 1'($urandom_range(0, 1));
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				mod_high = !mod_high;
				run_left = long_runs ? $urandom_range(256, 270) : $urandom_range(1, span);
			end
			run_left--;
			if ($urandom_range(0, 7) == 0)
				mods = DATA_W'($urandom);
			else if (mod_high)
				mods = -DATA_W'($urandom_range(0, 32768));
			else
				mods = DATA_W'($urandom_range(1, 32767));
			case ($urandom_range(0, 9))
				0: pe = 16'h8000;
				1: pe = 16'h7fff;
				2: pe = '0;
				3: pe = ($urandom_range(0, 1) == 1) ? 16'sd1 : -16'sd1;
				default: pe = DATA_W'($urandom);
			endcase
			dump = ($urandom_range(0, 39) == 0);
			send_item(pe, mods, dump);
		end
	endtask

	initial begin
		logic [7:0]         dref;
		logic [7:0]         mdly;
		logic signed [15:0] gn;
		logic signed [15:0] start;
		logic               closed;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: no delay, open loop, zero gain
		send_item(16'sd32767, 16'sd32767, 1'b0);
		send_item(-16'sd32768, 16'sd32767, 1'b0);
		send_item(16'sd0, -16'sd32768, 1'b0);
		send_item(16'sd1, 16'sd0, 1'b0);
		send_item(-16'sd1, 16'sd1, 1'b0);
		send_item(16'sd32767, -16'sd1, 1'b1);
		send_item(-16'sd32768, -16'sd32768, 1'b0);
		send_item(-16'sd32768, 16'sd32767, 1'b1);

		// short delay, full positive gain, closed loop from the top rail
		set_config(8'd3, 8'd255, 16'sd32767, 1'b1, 16'sd32767);
		send_item(16'sd100, 16'sd100, 1'b0);
		send_item(-16'sd100, 16'sd200, 1'b0);
		send_item(16'sd0, 16'sd300, 1'b0);
		send_item(16'sd32767, 16'sd400, 1'b0);
		send_item(16'sd5, -16'sd5, 1'b0);
		send_item(-16'sd5, -16'sd6, 1'b0);
		send_item(-16'sd32768, -16'sd7, 1'b0);
		send_item(16'sd77, 16'sd0, 1'b1);
		send_item(-16'sd77, 16'sd1, 1'b0);
		send_item(16'sd1, 16'sd2, 1'b0);

		// delay above the maximum delay is clamped; most negative start and gain
		set_config(8'd200, 8'd2, -16'sd32768, 1'b1, -16'sd32768);
		send_item(16'sd100, -16'sd1, 1'b0);
		send_item(-16'sd100, -16'sd1, 1'b0);
		send_item(16'sd0, -16'sd1, 1'b0);
		send_item(16'sd32767, 16'sd5, 1'b0);
		send_item(-16'sd32768, 16'sd5, 1'b0);
		send_item(16'sd7, 16'sd5, 1'b1);

		// runs longer than the counters can hold
		gn = 16'($urandom);
		set_config(8'd255, 8'd255, gn, 1'b0, 16'sd32767);
		modulated_run(280, 1'b1, 1'b0, 1'b1);

		for (int k = 0; k < 10; k++) begin
			dref = ($urandom_range(0, 3) == 0) ? 8'd0 :
				($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(1, 12));
			mdly = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) :
				8'($urandom_range(1, 16));
			if (k == 2) mdly = 8'd1;
			gn = 16'($urandom);
			if (k == 3) gn = -16'sd32768;
			if (k == 4) gn = 16'sd32767;
			closed = (k % 3 != 0);
			start = 16'($urandom);
			if (k == 5) start = -16'sd32767;
			set_config(dref, mdly, gn, closed, start);
			modulated_run(70, (k % 4 != 1) && (k != 6), k == 6, 1'b0);
		end

		// tail end runs back to back on both sides
		gn = 16'($urandom);
		start = 16'($urandom);
		set_config(8'($urandom_range(1, 10)), 8'($urandom_range(1, 20)), gn, 1'b1, start);
		modulated_run(80, 1'b0, 1'b0, 1'b0);
		drain();

		if (sb.pending() > 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		$display("covered %0d items over %0d register settings, %0d results compared",
			sb.inputs, settings, sb.results);
		$display("rate register dumped %0d times, %0d mismatches", sb.dumps, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
